/* hdl/str_pkg.sv */
// Shared types, constants and helper functions for the shaded triangle rasteriser.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
package str_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int CHAN_BITS  = 8;
  localparam int VAL_BITS   = (COORD_BITS > CHAN_BITS) ? COORD_BITS : CHAN_BITS;
  localparam int ACC_W      = VAL_BITS + FRAC_BITS + 2;
  localparam int CNT_W      = $clog2(ACC_W + 1);
  localparam int SHADE_W    = CHAN_BITS + FRAC_BITS;
  localparam int PROD_W     = 2 * CHAN_BITS;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [COORD_BITS-1:0]   coord_t;

  typedef struct packed {
    logic        mode;
    logic [9:0]  ax;
    logic [9:0]  ay;
    logic [7:0]  ah;
    logic [9:0]  bx;
    logic [9:0]  by;
    logic [7:0]  bh;
    logic [9:0]  cx;
    logic [9:0]  cy;
    logic [7:0]  ch;
    logic [23:0] base_color;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [23:0] pixel_color;
    logic        last;
  } out_item_t;

  typedef struct packed {
    coord_t               x;
    coord_t               y;
    logic [CHAN_BITS-1:0] h;
  } vtx_t;

  localparam logic MODE_LOAD = 1'b0;

  typedef enum logic [2:0] {
    JOB_LONG_X,
    JOB_LONG_H,
    JOB_SHORT_X,
    JOB_SHORT_H,
    JOB_SPAN
  } job_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_ROW,
    ST_SPAN,
    ST_WAIT,
    ST_SHADE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic row_enter;
    logic span_setup;
    logic div_start;
    logic shade;
    logic emit;
    job_e job;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic enter_lower;
    logic span_more;
    logic last_row;
    logic out_free;
  } status_t;

  // Integer part of an edge accumulator, clamped to the coordinate range
  function automatic coord_t int_part(acc_t a);
    acc_t v;
    v = a >>> FRAC_BITS;
    if (a < 0) return '0;
    if (v > acc_t'((2 ** COORD_BITS) - 1)) return '1;
    return v[COORD_BITS-1:0];
  endfunction

  // Fixed-point edge numerator: (d1 - d0) scaled by one
  function automatic acc_t edge_num(logic [VAL_BITS-1:0] d0, logic [VAL_BITS-1:0] d1);
    logic signed [VAL_BITS:0] d;
    d = $signed({1'b0, d1}) - $signed({1'b0, d0});
    return acc_t'(d) <<< FRAC_BITS;
  endfunction

  // Exact floor(p / 255) for p up to 255 * 255
  function automatic logic [CHAN_BITS-1:0] div255(logic [PROD_W-1:0] p);
    logic [CHAN_BITS-1:0] q0;
    logic [CHAN_BITS:0]   r;
    q0 = p[PROD_W-1:CHAN_BITS];
    r  = {1'b0, p[CHAN_BITS-1:0]} + {1'b0, q0};
    return (r >= (CHAN_BITS + 1)'(255)) ? q0 + CHAN_BITS'(1) : q0;
  endfunction

endpackage

/* hdl/shaded_triangle_rasterizer_core.sv */
// Top level of the shaded triangle rasteriser: controller plus datapath.
// Depends on str_pkg, str_ctrl and str_datapath (which holds str_div).
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i / in_ready_o   | str_pkg::in_item_t
//   out     | output    | out_valid_o / out_ready_i | str_pkg::out_item_t
//
// A load word takes 4 slope divisions on the shared radix-2 divider, plus one
// span division for the first row.
// A step word within a span passes through accept, shade multiply and output.
// A step that ends a row adds one span division, two more on entering the lower half.
// Reset clears the controller to idle and empties the output register.
// A stalled output holds the block in its output state; no word is taken meanwhile.
`timescale 1ns / 1ps
module shaded_triangle_rasterizer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  str_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output str_pkg::out_item_t  out_data_o
);
  import str_pkg::*;

  cmd_t    cmd;
  status_t status;

  str_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_mode_i  (in_data_i.mode),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  str_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* hdl/str_div.sv */
// Radix-2 restoring divider for slopes: signed numerator over unsigned denominator.
// Truncates toward zero; a zero denominator gives zero. Depends on str_pkg.
`timescale 1ns / 1ps
module str_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  str_pkg::acc_t num_i,
  input  str_pkg::coord_t den_i,
  output logic          done_o,
  output str_pkg::acc_t quo_o
);
  import str_pkg::*;

  logic [ACC_W-1:0]  quo_q, quo_d;
  coord_t            rem_q, rem_d;
  coord_t            den_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              neg_q, zero_q, done_q, done_d;
  logic [COORD_BITS:0] rem_sh;

  // One quotient bit a cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[ACC_W-1]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = (num_i < 0) ? ACC_W'(-num_i) : ACC_W'(num_i);
      rem_d = '0;
      cnt_d = CNT_W'(ACC_W);
    end else if (cnt_q != '0) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = COORD_BITS'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[ACC_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[COORD_BITS-1:0];
        quo_d = {quo_q[ACC_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q  <= den_i;
      neg_q  <= (num_i < 0);
      zero_q <= (den_i == '0);
    end
  end

  assign done_o = done_q;
  assign quo_o  = zero_q ? '0 : (neg_q ? -$signed(quo_q) : $signed(quo_q));

endmodule

/* hdl/str_datapath.sv */
// Datapath: sorted vertices, edge and span accumulators, shading and the output word.
// Depends on str_pkg and str_div.
`timescale 1ns / 1ps
module str_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  str_pkg::cmd_t       cmd_i,
  output str_pkg::status_t    status_o,
  input  str_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output str_pkg::out_item_t  out_data_o
);
  import str_pkg::*;

  vtx_t      vtx_q [3];
  vtx_t      srt [3];
  vtx_t      tmp;
  logic [23:0] color_q;
  acc_t      long_x_q, long_xs_q, long_h_q, long_hs_q;
  acc_t      short_x_q, short_xs_q, short_h_q, short_hs_q;
  acc_t      span_h_q, span_hs_q, span_num_q;
  coord_t    span_den_q;
  coord_t    cur_x_q, right_q, cur_y_q;
  logic      lower_q;
  logic [PROD_W-1:0] prod_q [3];
  out_item_t out_q;
  logic      out_valid_q;

  acc_t      div_num, div_quo;
  coord_t    div_den;
  logic      div_done;
  coord_t    lx, rx;
  acc_t      lh, rh;
  logic [SHADE_W-1:0] h_mag;
  logic      span_more, last_row;
  vtx_t      ea, eb;

  // Sort the incoming vertices by y with three compare-swaps
  always_comb begin
    tmp    = '0;
    srt[0] = '{coord_t'(in_data_i.ax), coord_t'(in_data_i.ay), in_data_i.ah};
    srt[1] = '{coord_t'(in_data_i.bx), coord_t'(in_data_i.by), in_data_i.bh};
    srt[2] = '{coord_t'(in_data_i.cx), coord_t'(in_data_i.cy), in_data_i.ch};
    if (srt[1].y < srt[0].y) begin
      tmp = srt[0]; srt[0] = srt[1]; srt[1] = tmp;
    end
    if (srt[2].y < srt[0].y) begin
      tmp = srt[0]; srt[0] = srt[2]; srt[2] = tmp;
    end
    if (srt[2].y < srt[1].y) begin
      tmp = srt[1]; srt[1] = srt[2]; srt[2] = tmp;
    end
  end

  // Pick the divider operands for the current job
  always_comb begin
    ea = lower_q ? vtx_q[1] : vtx_q[0];
    eb = lower_q ? vtx_q[2] : vtx_q[1];
    case (cmd_i.job)
      JOB_LONG_X: begin
        div_num = edge_num(VAL_BITS'(vtx_q[0].x), VAL_BITS'(vtx_q[2].x));
        div_den = vtx_q[2].y - vtx_q[0].y;
      end
      JOB_LONG_H: begin
        div_num = edge_num(VAL_BITS'(vtx_q[0].h), VAL_BITS'(vtx_q[2].h));
        div_den = vtx_q[2].y - vtx_q[0].y;
      end
      JOB_SHORT_X: begin
        div_num = edge_num(VAL_BITS'(ea.x), VAL_BITS'(eb.x));
        div_den = eb.y - ea.y;
      end
      JOB_SHORT_H: begin
        div_num = edge_num(VAL_BITS'(ea.h), VAL_BITS'(eb.h));
        div_den = eb.y - ea.y;
      end
      default: begin
        div_num = span_num_q;
        div_den = span_den_q;
      end
    endcase
  end

  str_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Span ends, swapped so that the cursor walks left to right
  always_comb begin
    lx = int_part(short_x_q);
    rx = int_part(long_x_q);
    lh = short_h_q;
    rh = long_h_q;
    if (rx < lx) begin
      lx = int_part(long_x_q);
      rx = int_part(short_x_q);
      lh = long_h_q;
      rh = short_h_q;
    end
  end

  assign h_mag     = (span_h_q > 0) ? span_h_q[SHADE_W-1:0] : '0;
  assign span_more = (cur_x_q < right_q);
  assign last_row  = lower_q && (cur_y_q >= vtx_q[2].y);

  // Triangle state and accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vtx_q     <= srt;
      color_q   <= in_data_i.base_color;
      long_x_q  <= acc_t'(srt[0].x) <<< FRAC_BITS;
      long_h_q  <= acc_t'(srt[0].h) <<< FRAC_BITS;
      short_x_q <= acc_t'(srt[0].x) <<< FRAC_BITS;
      short_h_q <= acc_t'(srt[0].h) <<< FRAC_BITS;
      cur_y_q   <= srt[0].y;
      lower_q   <= 1'b0;
    end
    if (cmd_i.row_enter) begin
      lower_q   <= 1'b1;
      short_x_q <= acc_t'(vtx_q[1].x) <<< FRAC_BITS;
      short_h_q <= acc_t'(vtx_q[1].h) <<< FRAC_BITS;
    end
    if (div_done) begin
      case (cmd_i.job)
        JOB_LONG_X:  long_xs_q  <= div_quo;
        JOB_LONG_H:  long_hs_q  <= div_quo;
        JOB_SHORT_X: short_xs_q <= div_quo;
        JOB_SHORT_H: short_hs_q <= div_quo;
        default:     span_hs_q  <= div_quo;
      endcase
    end
    if (cmd_i.span_setup) begin
      cur_x_q    <= lx;
      right_q    <= rx;
      span_h_q   <= lh;
      span_num_q <= rh - lh;
      span_den_q <= rx - lx;
    end
    // Multiply at full width before dropping the fraction bits
    if (cmd_i.shade) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= PROD_W'(((SHADE_W + CHAN_BITS)'(color_q[8*(2-i) +: 8]) * h_mag)
                             >> FRAC_BITS);
      end
    end
    // Advance the cursor along the span, or step every edge down one row
    if (cmd_i.emit) begin
      if (span_more) begin
        cur_x_q  <= cur_x_q + COORD_BITS'(1);
        span_h_q <= span_h_q + span_hs_q;
      end else begin
        long_x_q  <= long_x_q + long_xs_q;
        long_h_q  <= long_h_q + long_hs_q;
        short_x_q <= short_x_q + short_xs_q;
        short_h_q <= short_h_q + short_hs_q;
        if (!last_row) cur_y_q <= cur_y_q + COORD_BITS'(1);
      end
      out_q.pixel_x     <= 10'(cur_x_q);
      out_q.pixel_y     <= 10'(cur_y_q);
      out_q.pixel_color <= {div255(prod_q[0]), div255(prod_q[1]), div255(prod_q[2])};
      out_q.last        <= !span_more && last_row;
    end
  end

  // Output word valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.div_done    = div_done;
  assign status_o.enter_lower = !lower_q && (cur_y_q >= vtx_q[1].y);
  assign status_o.span_more   = span_more;
  assign status_o.last_row    = last_row;
  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign out_data_o           = out_q;

endmodule

/* hdl/str_ctrl.sv */
// Controller: sequences triangle load, slope divisions, span setup and fragment output.
// Depends on str_pkg.
`timescale 1ns / 1ps
module str_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_mode_i,
  input  str_pkg::status_t status_i,
  output str_pkg::cmd_t    cmd_o
);
  import str_pkg::*;

  state_e state_q, state_d;
  job_e   job_q, job_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= JOB_LONG_X;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    cmd_o      = '0;
    cmd_o.job  = job_q;
    in_ready_o = (state_q == ST_IDLE) || (state_q == ST_WAIT);
    accept     = in_valid_i && in_ready_o;
    case (state_q)
      ST_IDLE, ST_WAIT: begin
        if (accept) begin
          if (in_mode_i == MODE_LOAD) begin
            cmd_o.load = 1'b1;
            job_d      = JOB_LONG_X;
            state_d    = ST_DIV_START;
          end else if (state_q == ST_WAIT) begin
            state_d = ST_SHADE;
          end
        end
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          case (job_q)
            JOB_LONG_X: begin
              job_d = JOB_LONG_H;  state_d = ST_DIV_START;
            end
            JOB_LONG_H: begin
              job_d = JOB_SHORT_X; state_d = ST_DIV_START;
            end
            JOB_SHORT_X: begin
              job_d = JOB_SHORT_H; state_d = ST_DIV_START;
            end
            JOB_SHORT_H: state_d = ST_ROW;
            default:     state_d = ST_WAIT;
          endcase
        end
      end
      ST_ROW: begin
        if (status_i.enter_lower) begin
          cmd_o.row_enter = 1'b1;
          job_d           = JOB_SHORT_X;
          state_d         = ST_DIV_START;
        end else begin
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        cmd_o.span_setup = 1'b1;
        job_d            = JOB_SPAN;
        state_d          = ST_DIV_START;
      end
      ST_SHADE: begin
        cmd_o.shade = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.span_more)     state_d = ST_WAIT;
          else if (status_i.last_row) state_d = ST_IDLE;
          else                        state_d = ST_ROW;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
